/* hdl/dtc_pkg.sv */
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants for the dual timer/counter
// Item layouts, code values and the control bundle between core and timers.
// ----------------------------------------------------------------------------
package dtc_pkg;

	// item kinds
	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_TICK  = 3'd2;
	localparam logic [2:0] KIND_GATE  = 3'd3;
	localparam logic [2:0] KIND_COUNT = 3'd4;

	// bus register selects
	localparam logic [1:0] SEL_CTRL = 2'd0;
	localparam logic [1:0] SEL_LOW  = 2'd1;
	localparam logic [1:0] SEL_HIGH = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_MODE_CONTROL = 3'd0;
	localparam logic [2:0] REG_PRESCALE0    = 3'd1;
	localparam logic [2:0] REG_PRESCALE1    = 3'd2;
	localparam logic [2:0] REG_FAST0        = 3'd3;
	localparam logic [2:0] REG_FAST1        = 3'd4;

	// timer modes
	localparam logic [1:0] MODE_RELOAD16 = 2'd0;
	localparam logic [1:0] MODE_WRAP16   = 2'd1;
	localparam logic [1:0] MODE_RELOAD8  = 2'd2;
	localparam logic [1:0] MODE_SPLIT    = 2'd3;

	// control flag bit positions
	localparam int unsigned CF_IT0 = 0;
	localparam int unsigned CF_IE0 = 1;
	localparam int unsigned CF_IT1 = 2;
	localparam int unsigned CF_IE1 = 3;
	localparam int unsigned CF_TR0 = 4;
	localparam int unsigned CF_TF0 = 5;
	localparam int unsigned CF_TR1 = 6;
	localparam int unsigned CF_TF1 = 7;

	// mode control bit positions
	localparam int unsigned MC_CT0   = 2;
	localparam int unsigned MC_GATE0 = 3;
	localparam int unsigned MC_CT1   = 6;
	localparam int unsigned MC_GATE1 = 7;

	typedef struct packed {
		logic [2:0] kind;
		logic       channel;
		logic [1:0] reg_select;
		logic [7:0] write_data;
		logic       pin_level;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       ext0_irq;
		logic       timer0_irq;
		logic       ext1_irq;
		logic       timer1_irq;
		logic       overflow_pulse;
	} result_t;

	// per-timer control from the core, valid for the item being processed
	typedef struct packed {
		logic       tick;
		logic       wr_low;
		logic       wr_high;
		logic       pin_ev;
		logic       pin_level;
		logic [7:0] data;
		logic [1:0] mode;
		logic       run;
		logic       act_tick;
		logic       act_cnt;
		logic [7:0] prescale;
		logic       fast;
		logic       clr_all;
		logic       clr_cycle;
	} tmr_ctl_t;

	typedef struct packed {
		logic [7:0] count_low;
		logic [7:0] count_high;
		logic       ovf;
	} tmr_sts_t;

endpackage

/* hdl/dtc_timer.sv */
// ----------------------------------------------------------------------------
// dtc_timer: one timer/counter channel
// Holds counter, reload bytes, prescale dividers and the count pin level.
// ----------------------------------------------------------------------------
module dtc_timer
	import dtc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  tmr_ctl_t ctl,
	output tmr_sts_t sts
);

	logic [7:0]  count_low_q, count_high_q, reload_low_q, reload_high_q;
	logic [11:0] cycle_cnt_q;
	logic [7:0]  edge_cnt_q;
	logic        count_pin_q;

	logic [8:0]  pre_plus;
	logic [11:0] div_limit;
	logic [12:0] cycle_inc;
	logic        cycle_full, tick_adv, falling, edge_adv, adv;
	logic [15:0] value, value_inc, next16;
	logic        ovf;
	logic [7:0]  next_low8;

	// cycle divider limit: (1 or 12) * (prescale + 1)
	assign pre_plus  = {1'b0, ctl.prescale} + 9'd1;
	assign div_limit = ctl.fast ? {3'b000, pre_plus}
		: ({pre_plus, 3'b000} + {1'b0, pre_plus, 2'b00});
	assign cycle_inc  = {1'b0, cycle_cnt_q} + 13'd1;
	assign cycle_full = cycle_inc >= {1'b0, div_limit};
	assign tick_adv   = ctl.tick && ctl.act_tick && cycle_full;

	// falling count pin edge through the edge divider
	assign falling  = ctl.pin_ev && count_pin_q && !ctl.pin_level;
	assign edge_adv = falling && ctl.act_cnt && (edge_cnt_q == ctl.prescale);
	assign adv      = tick_adv || edge_adv;

	// next counter value on one count
	assign value     = {count_high_q, count_low_q};
	assign value_inc = value + 16'd1;
	always_comb begin
		next16    = value_inc;
		next_low8 = count_low_q + 8'd1;
		if (ctl.mode == MODE_RELOAD8) begin
			ovf = &count_low_q;
			if (ovf) begin
				next_low8 = count_high_q;
			end
		end else begin
			ovf = &value;
			if (ovf) begin
				next16 = (ctl.mode == MODE_RELOAD16) ? {reload_high_q, reload_low_q} : 16'd0;
			end
		end
	end

	assign sts.count_low  = count_low_q;
	assign sts.count_high = count_high_q;
	assign sts.ovf        = adv && ovf;

	// dividers and pin level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_cnt_q <= '0;
			edge_cnt_q  <= '0;
			count_pin_q <= 1'b1;
		end else begin
			if (ctl.clr_all) begin
				cycle_cnt_q <= '0;
				edge_cnt_q  <= '0;
			end else if (ctl.clr_cycle) begin
				cycle_cnt_q <= '0;
			end else begin
				if (ctl.tick && ctl.act_tick) begin
					cycle_cnt_q <= cycle_full ? 12'd0 : cycle_inc[11:0];
				end
				if (falling && ctl.act_cnt) begin
					edge_cnt_q <= edge_adv ? 8'd0 : edge_cnt_q + 8'd1;
				end
			end
			if (ctl.pin_ev) begin
				count_pin_q <= ctl.pin_level;
			end
		end
	end

	// counter and reload bytes: bus writes or a count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_low_q   <= '0;
			count_high_q  <= '0;
			reload_low_q  <= '0;
			reload_high_q <= '0;
		end else if (adv) begin
			if (ctl.mode == MODE_RELOAD8) begin
				count_low_q <= next_low8;
			end else begin
				count_low_q  <= next16[7:0];
				count_high_q <= next16[15:8];
			end
		end else if (ctl.wr_low || ctl.wr_high) begin
			if (ctl.mode == MODE_RELOAD8) begin
				if (ctl.wr_low) count_low_q <= ctl.data;
				else count_high_q <= ctl.data;
			end else if (ctl.mode == MODE_RELOAD16 && ctl.run) begin
				if (ctl.wr_low) reload_low_q <= ctl.data;
				else reload_high_q <= ctl.data;
			end else begin
				if (ctl.wr_low) begin
					count_low_q  <= ctl.data;
					reload_low_q <= ctl.data;
				end else begin
					count_high_q  <= ctl.data;
					reload_high_q <= ctl.data;
				end
			end
		end
	end

endmodule

/* hdl/dual_timer_counter_8051_style_core.sv */
// ----------------------------------------------------------------------------
// dual_timer_counter_8051_style_core: two timer/counters with prescalers
// Item register, control flag logic, two timer channels and a result register.
// ----------------------------------------------------------------------------
// An item waits in the item register; its result is registered when it fires.
// Throughput: one item per cycle unless a waiting result stalls; the item and
// result registers hold one item each; a waiting result stalls a full one.
// Reset clears flags, counters and dividers, sets pin levels high and
// leaves the item and result registers empty.
module dual_timer_counter_8051_style_core
	import dtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  item_t      req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output result_t    rsp,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	logic        valid_s1;
	item_t       item_s1;
	logic        fire;

	logic [7:0]  mode_control_q;
	logic [7:0]  prescale_q [2];
	logic        fast_q [2];
	logic [7:0]  control_q;
	logic [1:0]  gate_q;

	logic [7:0]  control_n;
	logic [1:0]  gate_n;
	tmr_ctl_t    ctl [2];
	tmr_sts_t    sts [2];
	logic [1:0]  mode_raw [2];
	logic [1:0]  base_act;
	logic [1:0]  ct_sel;
	logic [1:0]  gate_en;
	logic [1:0]  run;
	result_t     rsp_n;
	logic [7:0]  rd;

	// handshake and item register
	assign fire      = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_control_q <= '0;
			prescale_q[0]  <= '0;
			prescale_q[1]  <= '0;
			fast_q[0]      <= 1'b0;
			fast_q[1]      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE_CONTROL: mode_control_q <= cfg_wdata;
				REG_PRESCALE0:    prescale_q[0] <= cfg_wdata;
				REG_PRESCALE1:    prescale_q[1] <= cfg_wdata;
				REG_FAST0:        fast_q[0] <= cfg_wdata[0];
				REG_FAST1:        fast_q[1] <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// per-timer mode fields and activity
	assign mode_raw[0] = mode_control_q[1:0];
	assign mode_raw[1] = mode_control_q[5:4];
	assign ct_sel  = {mode_control_q[MC_CT1], mode_control_q[MC_CT0]};
	assign gate_en = {mode_control_q[MC_GATE1], mode_control_q[MC_GATE0]};
	assign run     = {control_q[CF_TR1], control_q[CF_TR0]};

	always_comb begin
		for (int n = 0; n < 2; n++) begin
			base_act[n] = run[n] && (!gate_en[n] || gate_q[n]);
		end
		// timer 1 in split mode is stopped
		if (mode_raw[1] == MODE_SPLIT) base_act[1] = 1'b0;
	end

	// control bundles for the two channels
	always_comb begin
		for (int n = 0; n < 2; n++) begin
			ctl[n].tick      = fire && item_s1.kind == KIND_TICK;
			ctl[n].wr_low    = fire && item_s1.kind == KIND_WRITE
				&& item_s1.channel == n[0] && item_s1.reg_select == SEL_LOW;
			ctl[n].wr_high   = fire && item_s1.kind == KIND_WRITE
				&& item_s1.channel == n[0] && item_s1.reg_select == SEL_HIGH;
			ctl[n].pin_ev    = fire && item_s1.kind == KIND_COUNT && item_s1.channel == n[0];
			ctl[n].pin_level = item_s1.pin_level;
			ctl[n].data      = item_s1.write_data;
			ctl[n].mode      = mode_raw[n];
			ctl[n].run       = run[n];
			ctl[n].act_tick  = base_act[n] && !ct_sel[n];
			ctl[n].act_cnt   = base_act[n] && ct_sel[n];
			ctl[n].prescale  = prescale_q[n];
			ctl[n].fast      = fast_q[n];
			ctl[n].clr_all   = cfg_we
				&& cfg_index == (n[0] ? REG_PRESCALE1 : REG_PRESCALE0);
			ctl[n].clr_cycle = cfg_we && cfg_index == (n[0] ? REG_FAST1 : REG_FAST0)
				&& cfg_wdata[0] != fast_q[n];
		end
		// timer 0 in split mode runs as 16-bit auto-reload
		if (mode_raw[0] == MODE_SPLIT) ctl[0].mode = MODE_RELOAD16;
	end

	dtc_timer u_timer0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl[0]),
		.sts    (sts[0])
	);

	dtc_timer u_timer1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl[1]),
		.sts    (sts[1])
	);

	// next control flags and gate levels
	always_comb begin
		control_n = control_q;
		gate_n    = gate_q;
		case (item_s1.kind)
			KIND_WRITE: begin
				if (item_s1.reg_select == SEL_CTRL) control_n = item_s1.write_data;
			end
			KIND_GATE: begin
				gate_n[item_s1.channel] = item_s1.pin_level;
				if (!item_s1.channel) begin
					if (control_q[CF_IT0]) begin
						if (gate_q[0] && !item_s1.pin_level) control_n[CF_IE0] = 1'b1;
					end else begin
						control_n[CF_IE0] = !item_s1.pin_level;
					end
				end else begin
					if (control_q[CF_IT1]) begin
						if (gate_q[1] && !item_s1.pin_level) control_n[CF_IE1] = 1'b1;
					end else begin
						control_n[CF_IE1] = !item_s1.pin_level;
					end
				end
			end
			KIND_TICK, KIND_COUNT: begin
				if (sts[0].ovf) control_n[CF_TF0] = 1'b1;
				if (sts[1].ovf) control_n[CF_TF1] = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			gate_q    <= 2'b11;
		end else if (fire) begin
			control_q <= control_n;
			gate_q    <= gate_n;
		end
	end

	// read data
	always_comb begin
		rd = '0;
		if (item_s1.kind == KIND_READ) begin
			case (item_s1.reg_select)
				SEL_CTRL: rd = control_q;
				SEL_LOW:  rd = sts[item_s1.channel].count_low;
				SEL_HIGH: rd = sts[item_s1.channel].count_high;
				default:  rd = '0;
			endcase
		end
	end

	// result assembly
	always_comb begin
		rsp_n.read_data      = rd;
		rsp_n.ext0_irq       = control_n[CF_IT0] ? control_n[CF_IE0] : !gate_n[0];
		rsp_n.timer0_irq     = control_n[CF_TF0];
		rsp_n.ext1_irq       = control_n[CF_IT1] ? control_n[CF_IE1] : !gate_n[1];
		rsp_n.timer1_irq     = control_n[CF_TF1];
		rsp_n.overflow_pulse = sts[0].ovf;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (fire) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp <= rsp_n;
		end
	end

	// checks
	a_pulse_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.overflow_pulse |-> rsp.timer0_irq)
		else $error("overflow pulse without timer 0 flag");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> valid_s1 && rsp_valid && !rsp_ready)
		else $error("input stalled without a held result");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.kind != KIND_READ |=> rsp.read_data == 8'd0)
		else $error("non-read item returned read data");

	a_tf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && control_q[CF_TF0] && item_s1.kind != KIND_WRITE |=> control_q[CF_TF0])
		else $error("timer 0 flag cleared without a control write");

endmodule
